@@ rtl/channel_level_peak_tracker_assert.svh @@
// Assertion macros shared by the tracker RTL.
`ifndef CHANNEL_LEVEL_PEAK_TRACKER_ASSERT_SVH
`define CHANNEL_LEVEL_PEAK_TRACKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CLPT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CLPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLPT_ASSERT(lbl, clk, rstn, prop, msg)
`define CLPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ rtl/clpt_pkg.sv @@
// Package with types, constants and the level function of the peak tracker.
package clpt_pkg;

    localparam int HISTORY_DEPTH   = 120;
    localparam int CHANNEL_COUNT   = 128;
    localparam int PROBE_COUNT     = 5;
    localparam int LEVEL_CAP       = 10;
    localparam int LEVEL_PER_PROBE = 2;

    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;
    localparam logic [1:0] ACT_DOWN   = 2'd2;
    localparam logic [1:0] ACT_BOTH   = 2'd3;

    localparam logic [6:0] CHAN_MAX = 7'(CHANNEL_COUNT - 1);

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] probe_bits;
    } in_t;

    typedef struct packed {
        logic [6:0] channel;
        logic [3:0] level;
        logic [3:0] peak;
    } out_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    function automatic logic [3:0] probe_level(input logic [4:0] bits);
        logic [4:0] acc;
        acc = 5'd0;
        for (int i = 0; i < PROBE_COUNT; i++) begin
            if (bits[i]) begin
                acc = acc + 5'(LEVEL_PER_PROBE);
            end
        end
        if (acc > 5'(LEVEL_CAP)) begin
            acc = 5'(LEVEL_CAP);
        end
        return acc[3:0];
    endfunction

endpackage

@@ rtl/clpt_cell.sv @@
// One history cell: holds a level and passes it on down the chain.
module clpt_cell (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  clpt_pkg::cell_ctrl_t  ctrl,
    input  logic [3:0]            d_in,
    output logic [3:0]            q
);

    logic [3:0] lvl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            lvl_reg <= 4'd0;
        end else if (ctrl.shift) begin
            lvl_reg <= d_in;
        end
    end

    assign q = lvl_reg;

endmodule

@@ rtl/channel_level_peak_tracker.sv @@
// Top level of the channel level peak tracker: control, cell chain, output register.
// Output: a result is registered on acceptance, or at the end of a rescan, or is held
// in ST_HOLD while the output is busy. Throughput: 1 item per cycle while the output is
// free, except a sample at write slot 0 not raising the peak: it rotates the cell chain
// once around, one cell per cycle into the running maximum, before the next is taken.
// Reset: synchronous, active low; clears cells, slot, peak, channel and handshakes.
`include "channel_level_peak_tracker_assert.svh"

module channel_level_peak_tracker #(
    parameter int HISTORY_DEPTH = clpt_pkg::HISTORY_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  clpt_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output clpt_pkg::out_t  m_data
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [SLOT_W-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [3:0]          scan_max_reg, scan_max_next;
    logic [3:0]          peak_reg, peak_next;
    logic [3:0]          level_reg, level_next;
    logic [6:0]          chan_reg, chan_next;
    logic                m_valid_reg, m_valid_next;
    clpt_pkg::out_t      m_data_reg, m_data_next;
    clpt_pkg::out_t      res_reg, res_next;

    clpt_pkg::cell_ctrl_t ctrl;
    logic [3:0]          cell_q [HISTORY_DEPTH];
    logic [3:0]          head_in;
    logic [3:0]          tail;
    logic [3:0]          new_level;
    logic [3:0]          scan_peak;
    logic                accept;
    logic                is_sample;
    logic                out_free;
    logic                done;
    clpt_pkg::out_t      result;

    assign accept    = s_valid && s_ready;
    assign is_sample = (s_data.action == clpt_pkg::ACT_SAMPLE);
    assign new_level = clpt_pkg::probe_level(s_data.probe_bits);
    assign out_free  = !m_valid_reg || m_ready;
    assign tail      = cell_q[HISTORY_DEPTH-1];
    assign scan_peak = (tail > scan_max_reg) ? tail : scan_max_reg;
    assign head_in   = (state_reg == ST_SCAN) ? tail : new_level;

    assign ctrl.shift = (accept && is_sample) || (state_reg == ST_SCAN);
    assign ctrl.clear = accept && !is_sample;

    for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            clpt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .d_in    (head_in),
                .q       (cell_q[i])
            );
        end else begin : g_body
            clpt_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .d_in    (cell_q[i-1]),
                .q       (cell_q[i])
            );
        end
    end

    always_comb begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        scan_cnt_next = scan_cnt_reg;
        scan_max_next = scan_max_reg;
        peak_next     = peak_reg;
        level_next    = level_reg;
        chan_next     = chan_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        done          = 1'b0;
        result        = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (is_sample) begin
                        level_next = new_level;
                        slot_next  = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                        if (new_level > peak_reg) begin
                            peak_next = new_level;
                            result    = '{channel: chan_reg, level: new_level,
                                          peak: new_level};
                            done      = 1'b1;
                        end else if (slot_reg == '0) begin
                            scan_cnt_next = '0;
                            scan_max_next = 4'd0;
                            state_next    = ST_SCAN;
                        end else begin
                            result = '{channel: chan_reg, level: new_level,
                                       peak: peak_reg};
                            done   = 1'b1;
                        end
                    end else begin
                        case (s_data.action)
                            clpt_pkg::ACT_UP: begin
                                chan_next = (chan_reg == clpt_pkg::CHAN_MAX) ?
                                            7'd0 : chan_reg + 7'd1;
                            end
                            clpt_pkg::ACT_DOWN: begin
                                chan_next = (chan_reg == 7'd0) ?
                                            clpt_pkg::CHAN_MAX : chan_reg - 7'd1;
                            end
                            clpt_pkg::ACT_BOTH: begin
                                chan_next = chan_reg;
                            end
                            default: begin
                                chan_next = chan_reg;
                            end
                        endcase
                        level_next = 4'd0;
                        peak_next  = 4'd0;
                        slot_next  = '0;
                        result     = '{channel: chan_next, level: 4'd0, peak: 4'd0};
                        done       = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                scan_max_next = scan_peak;
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == SLOT_LAST) begin
                    peak_next = scan_peak;
                    result    = '{channel: chan_reg, level: level_reg, peak: scan_peak};
                    done      = 1'b1;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (done) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_data_next  = result;
                state_next   = ST_IDLE;
            end else begin
                res_next   = result;
                state_next = ST_HOLD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            scan_cnt_reg <= '0;
            scan_max_reg <= 4'd0;
            peak_reg     <= 4'd0;
            level_reg    <= 4'd0;
            chan_reg     <= 7'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            scan_cnt_reg <= scan_cnt_next;
            scan_max_reg <= scan_max_next;
            peak_reg     <= peak_next;
            level_reg    <= level_next;
            chan_reg     <= chan_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        res_reg    <= res_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `CLPT_ASSERT(a_peak_covers_level, aclk, aresetn, m_valid |-> (m_data.peak >= m_data.level), "peak below level of result")
    `CLPT_ASSERT(a_level_capped, aclk, aresetn, m_valid |-> (m_data.peak <= 4'(clpt_pkg::LEVEL_CAP)), "peak above cap")
    `CLPT_ASSERT(a_button_clears, aclk, aresetn, (accept && !is_sample) |=> (peak_reg == 4'd0 && slot_reg == '0), "button did not clear history")
    `CLPT_ASSERT_ALWAYS(a_scan_blocks_input, aclk, (state_reg == ST_SCAN) |-> !s_ready, "input taken during rescan")

endmodule

@@ tb/clpt_result_checker.sv @@
// Checker for the channel level peak tracker: tracks state, predicts and compares results.
module clpt_result_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic            s_ready,
    input  clpt_pkg::in_t   s_data,
    input  logic            m_valid,
    input  logic            m_ready,
    input  clpt_pkg::out_t  m_data,
    output int              mismatches,
    output int              awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    logic [3:0]     level_history [clpt_pkg::HISTORY_DEPTH];
    logic [6:0]     next_slot;
    logic [3:0]     peak_seen;
    logic [6:0]     tuned_channel;
    clpt_pkg::out_t expected_results [$];

    initial begin
        mismatches = 0;
        awaited    = 0;
    end

    function automatic logic [3:0] level_of_probes(input logic [4:0] bits);
        int lvl;
        lvl = clpt_pkg::LEVEL_PER_PROBE * $countones(bits[clpt_pkg::PROBE_COUNT-1:0]);
        if (lvl > clpt_pkg::LEVEL_CAP) begin
            lvl = clpt_pkg::LEVEL_CAP;
        end
        return 4'(lvl);
    endfunction

    function automatic void forget_history();
        for (int i = 0; i < clpt_pkg::HISTORY_DEPTH; i++) begin
            level_history[i] = 4'd0;
        end
        next_slot = 7'd0;
        peak_seen = 4'd0;
    endfunction

    function automatic clpt_pkg::out_t track_transaction(input clpt_pkg::in_t tr);
        clpt_pkg::out_t res;
        logic [3:0]     lvl;
        lvl = 4'd0;
        if (tr.action == clpt_pkg::ACT_SAMPLE) begin
            lvl = level_of_probes(tr.probe_bits);
            level_history[next_slot] = lvl;
            if (lvl > peak_seen) begin
                peak_seen = lvl;
            end else if (next_slot == 7'd0) begin
                peak_seen = 4'd0;
                for (int i = 0; i < clpt_pkg::HISTORY_DEPTH; i++) begin
                    if (level_history[i] > peak_seen) begin
                        peak_seen = level_history[i];
                    end
                end
            end
            next_slot = (next_slot == 7'(clpt_pkg::HISTORY_DEPTH - 1)) ?
                        7'd0 : next_slot + 7'd1;
        end else begin
            case (tr.action)
                clpt_pkg::ACT_UP: begin
                    tuned_channel = (tuned_channel == clpt_pkg::CHAN_MAX) ?
                                    7'd0 : tuned_channel + 7'd1;
                end
                clpt_pkg::ACT_DOWN: begin
                    tuned_channel = (tuned_channel == 7'd0) ?
                                    clpt_pkg::CHAN_MAX : tuned_channel - 7'd1;
                end
                default: begin
                end
            endcase
            forget_history();
        end
        res.channel = tuned_channel;
        res.level   = lvl;
        res.peak    = peak_seen;
        return res;
    endfunction

    always @(posedge aclk) begin
        clpt_pkg::out_t due;
        if (!aresetn) begin
            forget_history();
            tuned_channel = 7'd0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected transaction: channel %0d level %0d peak %0d",
                                 m_data.channel, m_data.level, m_data.peak);
                    end
                end else begin
                    due = expected_results.pop_front();
                    if (m_data.channel !== due.channel || m_data.level !== due.level ||
                        m_data.peak !== due.peak) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display({"mismatch: expected channel %0d level %0d peak %0d,",
                                      " got channel %0d level %0d peak %0d"},
                                     due.channel, due.level, due.peak,
                                     m_data.channel, m_data.level, m_data.peak);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(track_transaction(s_data));
            end
        end
        awaited = expected_results.size();
    end

endmodule

@@ tb/tb_channel_level_peak_tracker.sv @@
// Testbench top for the channel level peak tracker: clock, reset, stimulus and verdict.
module tb_channel_level_peak_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int ITEMS_PER_PASS = 500;
    localparam int HOLD_OFF_LEN   = 400;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    clpt_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    clpt_pkg::out_t m_data;

    int mismatches;
    int results_awaited;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    channel_level_peak_tracker uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    clpt_result_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .awaited    (results_awaited)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_off_req && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_OFF_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [4:0] bits);
        clpt_pkg::in_t tr;
        tr.action     = act;
        tr.probe_bits = bits;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= tr;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_awaited != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic random_bursts(input int n_items);
        int         sent;
        int         run_len;
        int         mode;
        logic [4:0] bits;
        logic [1:0] act;
        sent = 0;
        while (sent < n_items) begin
            run_len = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(130, 260);
            mode    = $urandom_range(9);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
                bits = 5'($urandom);
                act  = clpt_pkg::ACT_SAMPLE;
                if (mode >= 6 && mode <= 8) begin
                    bits &= (k < 60) ? 5'h1F : (k < 180) ? 5'h03 : 5'h00;
                end else if (mode == 9) begin
                    act = 2'($urandom_range(3));
                end
                send_item(act, bits);
                sent++;
            end
            send_item(2'($urandom_range(1, 3)), 5'($urandom));
            sent++;
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_idle_pct = 14;
        recv_idle_pct = 45;
        send_item(clpt_pkg::ACT_SAMPLE, 5'h00);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h1F);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h01);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h10);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h07);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h0F);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h03);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h1E);
        send_item(clpt_pkg::ACT_DOWN,   5'h1F);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h1F);
        send_item(clpt_pkg::ACT_UP,     5'h00);
        send_item(clpt_pkg::ACT_UP,     5'h1F);
        send_item(clpt_pkg::ACT_UP,     5'h0A);
        send_item(clpt_pkg::ACT_BOTH,   5'h15);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h00);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h08);
        send_item(clpt_pkg::ACT_DOWN,   5'h00);
        send_item(clpt_pkg::ACT_DOWN,   5'h1F);
        send_item(clpt_pkg::ACT_BOTH,   5'h00);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h15);
        send_item(clpt_pkg::ACT_SAMPLE, 5'h0A);
        random_bursts(ITEMS_PER_PASS);
        drain_results();

        send_idle_pct = 45;
        recv_idle_pct = 14;
        random_bursts(ITEMS_PER_PASS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_req  = 1'b1;
        random_bursts(ITEMS_PER_PASS);
        drain_results();

        repeat (clpt_pkg::HISTORY_DEPTH + 20) @(negedge aclk);
        if (mismatches == 0 && results_awaited == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
